@@ rtl/iorb_pkg.sv @@
`default_nettype none

package iorb_pkg;

    localparam int ID_W = 6;
    localparam int NE_W = ID_W + 1;
    localparam logic [ID_W-1:0] LEN_RESET = 6'd32;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_READ
    } t_state;

    typedef struct packed {
        logic wr;
        logic rd;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic id_ok;
        logic ne_ok;
        logic next_ok;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

@@ rtl/in_order_release_buffer_unit.sv @@
`default_nettype none

// Reorder buffer that takes entries tagged with ids from one to the lesser of the configured
// stream length and DEPTH and releases their payloads in increasing id order, marking the
// final release of each run with o_last. An accepted entry is written in the idle state and
// the next expected slot is then checked in the check state; an entry with an id outside
// the stream is taken but not written. When releases follow, the payload memory read is
// issued in the check state and results then leave at one per cycle while the output side
// does not stall. A new entry is accepted only once the previous run has been fully handed
// to the output register.
module in_order_release_buffer_unit #(
    parameter int DEPTH         = 32,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [iorb_pkg::ID_W-1:0] i_cfg_data,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [iorb_pkg::ID_W-1:0] i_entry_id,
    input  wire logic [PAYLOAD_WIDTH-1:0]  i_payload,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic      [iorb_pkg::ID_W-1:0] o_released_id,
    output logic      [PAYLOAD_WIDTH-1:0]  o_released_value,
    output logic                           o_last
);

    import iorb_pkg::*;

    t_cmd    cmd;
    t_status status;

    iorb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    iorb_dpath #(
        .DEPTH         (DEPTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_entry_id       (i_entry_id),
        .i_payload        (i_payload),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_released_id    (o_released_id),
        .o_released_value (o_released_value),
        .o_last           (o_last),
        .i_cmd            (cmd),
        .o_status         (status)
    );

endmodule

`default_nettype wire

@@ rtl/iorb_ram.sv @@
`default_nettype none

module iorb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/iorb_ctrl.sv @@
`default_nettype none

module iorb_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire iorb_pkg::t_status i_status,
    output iorb_pkg::t_cmd         o_cmd
);

    import iorb_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_status.id_ok) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_status.ne_ok ? S_READ : S_IDLE;
            end
            S_READ: begin
                if (i_status.out_free && !i_status.next_ok) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.wr   = i_in_valid && i_status.id_ok;
            end
            S_CHECK: begin
                o_cmd.rd = i_status.ne_ok;
            end
            S_READ: begin
                o_cmd.load = i_status.out_free;
                o_cmd.rd   = i_status.out_free && i_status.next_ok;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/iorb_dpath.sv @@
`default_nettype none

module iorb_dpath #(
    parameter int DEPTH         = 32,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [iorb_pkg::ID_W-1:0] i_cfg_data,
    input  wire logic [iorb_pkg::ID_W-1:0] i_entry_id,
    input  wire logic [PAYLOAD_WIDTH-1:0]  i_payload,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic      [iorb_pkg::ID_W-1:0] o_released_id,
    output logic      [PAYLOAD_WIDTH-1:0]  o_released_value,
    output logic                           o_last,
    input  wire iorb_pkg::t_cmd            i_cmd,
    output iorb_pkg::t_status              o_status
);

    import iorb_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [NE_W-1:0] DEPTH_NE = NE_W'(DEPTH);

    logic [ID_W-1:0]          r_len;
    logic [NE_W-1:0]          r_ne;
    logic [NE_W-1:0]          n_ne;
    logic [DEPTH-1:0]         r_valid;
    logic [DEPTH-1:0]         n_valid;
    logic                     r_out_valid;
    logic                     n_out_valid;
    logic [ID_W-1:0]          r_out_id;
    logic [PAYLOAD_WIDTH-1:0] r_out_value;
    logic                     r_out_last;

    logic [NE_W-1:0]          len_eff;
    logic [NE_W-1:0]          id_ne;
    logic [NE_W-1:0]          id_m1;
    logic [NE_W-1:0]          ne_m1;
    logic [NE_W-1:0]          ne_p1;
    logic [AW-1:0]            id_idx;
    logic [AW-1:0]            ne_idx;
    logic [AW-1:0]            next_idx;
    logic [AW-1:0]            raddr;
    logic [PAYLOAD_WIDTH-1:0] rdata;

    assign len_eff  = ({1'b0, r_len} > DEPTH_NE) ? DEPTH_NE : {1'b0, r_len};
    assign id_ne    = {1'b0, i_entry_id};
    assign id_m1    = id_ne - NE_W'(1);
    assign ne_m1    = r_ne - NE_W'(1);
    assign ne_p1    = r_ne + NE_W'(1);
    assign id_idx   = id_m1[AW-1:0];
    assign ne_idx   = ne_m1[AW-1:0];
    assign next_idx = r_ne[AW-1:0];
    assign raddr    = i_cmd.load ? next_idx : ne_idx;

    assign o_status.id_ok    = (id_ne != '0) && (id_ne <= len_eff);
    assign o_status.ne_ok    = (r_ne != '0) && (r_ne <= len_eff) && r_valid[ne_idx];
    assign o_status.next_ok  = (ne_p1 <= len_eff) && r_valid[next_idx];
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_released_id    = r_out_id;
    assign o_released_value = r_out_value;
    assign o_last           = r_out_last;

    iorb_ram #(
        .WIDTH (PAYLOAD_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr),
        .i_waddr (id_idx),
        .i_wdata (i_payload),
        .i_re    (i_cmd.rd),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_valid = r_valid;
        if (i_cmd.wr) begin
            n_valid[id_idx] = 1'b1;
        end
        n_ne        = i_cmd.load ? ne_p1 : r_ne;
        n_out_valid = i_cmd.load || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= LEN_RESET;
            r_ne        <= NE_W'(1);
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_len <= i_cfg_data;
            end
            r_ne        <= n_ne;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_id    <= r_ne[ID_W-1:0];
            r_out_value <= rdata;
            r_out_last  <= !o_status.next_ok;
        end
    end

endmodule

`default_nettype wire

@@ rtl/iorb_checker.sv @@
`default_nettype none

module iorb_checker #(
    parameter int PAYLOAD_WIDTH = 32
) (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      o_in_ready,
    input wire logic                      o_out_valid,
    input wire logic                      i_out_ready,
    input wire logic [iorb_pkg::ID_W-1:0] o_released_id,
    input wire logic [PAYLOAD_WIDTH-1:0]  o_released_value,
    input wire logic                      o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("Output request dropped before it was taken.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_released_id) && $stable(o_released_value) && $stable(o_last))
        else $error("Output request changed while stalled.");

    a_no_insert_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> !o_in_ready)
        else $error("Input accepted while a release run was still in progress.");

    a_id_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_released_id != '0)
        else $error("Released request carries an id of zero.");

endmodule

bind in_order_release_buffer_unit iorb_checker #(
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
) u_iorb_checker (.*);

`default_nettype wire
